// ===== src/tsrp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrp_pkg
// shared widths, constants and types of the three-slew rate profile generator
// ----------------------------------------------------------------------------
`default_nettype none

package tsrp_pkg;

   localparam int NUM_SLEWS_DEF = 3;
   localparam int FLD_W         = 20;
   localparam int CFG_W         = 60;
   localparam int AXIS_W        = 6;
   localparam int NS_W          = 48;
   localparam int Q_W           = 31;

   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 48;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam int DIV_N_W = 80;
   localparam int DIV_D_W = 48;

   localparam int SQRT_V_W = 64;
   localparam int SQRT_R_W = SQRT_V_W / 2;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam logic [Q_W-1:0]  QMAX  = '1;
   localparam logic [NS_W-1:0] MAX48 = '1;

   localparam logic [21:0] K_TOTAL = 22'd3906250;
   localparam logic [20:0] K_RAMP  = 21'd1953125;
   localparam logic [29:0] K_NS    = 30'd1000000000;

   localparam logic [AXIS_W-1:0] AXIS_RESET = 6'd57;

   typedef enum logic [2:0] {
      REG_ANGLE   = 3'd0,
      REG_TIME    = 3'd1,
      REG_RLIM    = 3'd2,
      REG_AXIS    = 3'd3,
      REG_TORQUE  = 3'd4,
      REG_INERTIA = 3'd5
   } csr_reg_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PLAN_AMAX,
      ST_PLAN_TT,
      ST_PLAN_ALPHA,
      ST_PLAN_PEAK,
      ST_PLAN_TOT,
      ST_PLAN_Q,
      ST_PLAN_SQRT,
      ST_PLAN_RAMP2,
      ST_PLAN_PEAK2,
      ST_PLAN_LIMIT,
      ST_PLAN_RAMP3_MUL,
      ST_PLAN_RAMP3_DIV,
      ST_PLAN_COAST_MUL,
      ST_PLAN_COAST_DIV,
      ST_PLAN_STORE,
      ST_SCAN,
      ST_SEL,
      ST_RATE_MUL,
      ST_RATE_DIV,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// ===== src/tsrp_mul.sv =====
// ----------------------------------------------------------------------------
// tsrp_mul
// bit-serial shift-add multiplier, one bit of operand a per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tsrp_mul (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [tsrp_pkg::MUL_A_W-1:0] a,
   input  wire logic [tsrp_pkg::MUL_B_W-1:0] b,
   output logic                              done,
   output logic [tsrp_pkg::MUL_P_W-1:0]      prod
);

   localparam int CNT_W = $clog2(tsrp_pkg::MUL_A_W);

   logic [tsrp_pkg::MUL_A_W-1:0] a_ff, a_in;
   logic [tsrp_pkg::MUL_B_W-1:0] b_ff, b_in;
   logic [tsrp_pkg::MUL_P_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic                         last;

   assign last = (cnt_ff == CNT_W'(tsrp_pkg::MUL_A_W - 1));

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // msb first: shift partial sum, add b when the bit is set
         acc_in = {acc_ff[tsrp_pkg::MUL_P_W-2:0], 1'b0}
                  + (a_ff[tsrp_pkg::MUL_A_W-1] ? tsrp_pkg::MUL_P_W'(b_ff) : '0);
         a_in   = {a_ff[tsrp_pkg::MUL_A_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

`default_nettype wire

// ===== src/tsrp_div.sv =====
// ----------------------------------------------------------------------------
// tsrp_div
// restoring divider, one quotient bit per cycle, zero divisor gives all ones
// ----------------------------------------------------------------------------
`default_nettype none

module tsrp_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [tsrp_pkg::DIV_N_W-1:0] num,
   input  wire logic [tsrp_pkg::DIV_D_W-1:0] den,
   output logic                              done,
   output logic [tsrp_pkg::DIV_N_W-1:0]      quo
);

   localparam int N_W   = tsrp_pkg::DIV_N_W;
   localparam int D_W   = tsrp_pkg::DIV_D_W;
   localparam int CNT_W = $clog2(N_W);

   logic [N_W-1:0]   dq_ff, dq_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [D_W-1:0]   den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             zero_ff, zero_in;
   logic [D_W:0]     trial, diff;
   logic             ge;

   assign trial = {rem_ff, dq_ff[N_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      if (start) begin
         dq_in   = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
         zero_in = (den == '0);
      end else if (busy_ff) begin
         rem_in = ge ? diff[D_W-1:0] : trial[D_W-1:0];
         dq_in  = {dq_ff[N_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      zero_ff <= zero_in;
   end

   assign done = done_ff;
   assign quo  = zero_ff ? '1 : dq_ff;

endmodule

`default_nettype wire

// ===== src/tsrp_sqrt.sv =====
// ----------------------------------------------------------------------------
// tsrp_sqrt
// digit-by-digit integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tsrp_sqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [tsrp_pkg::SQRT_V_W-1:0] v,
   output logic                               done,
   output logic [tsrp_pkg::SQRT_R_W-1:0]      root
);

   localparam int V_W   = tsrp_pkg::SQRT_V_W;
   localparam int R_W   = tsrp_pkg::SQRT_R_W;
   localparam int CNT_W = $clog2(R_W);

   logic [V_W-1:0]   v_ff, v_in;
   logic [R_W-1:0]   rem_ff, rem_in;
   logic [R_W-1:0]   root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [R_W+1:0]   rem_sh, trial, diff;
   logic             ge;

   // partial remainder stays below 2*root, so its top bits are never needed
   assign rem_sh = {rem_ff, v_ff[V_W-1:V_W-2]};
   assign trial  = {root_ff, 2'b01};
   assign diff   = rem_sh - trial;
   assign ge     = (rem_sh >= trial);

   always_comb begin
      v_in    = v_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = v;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[R_W-1:0] : rem_sh[R_W-1:0];
         root_in = {root_ff[R_W-2:0], ge};
         v_in    = {v_ff[V_W-3:0], 2'b00};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(R_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

// ===== src/three_slew_rate_profile_generator.sv =====
// ----------------------------------------------------------------------------
// three_slew_rate_profile_generator
// plans back-to-back single-axis trapezoidal slews and samples rate references
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  req     | in        | req_valid / req_stall   | mode, time, body rates
//  rsp     | out       | rsp_valid / rsp_stall   | ref rate, ref accel, rate error
//  csr     | in        | psel / penable / pready | 64-bit registers at 8*index
//
//  one item at a time through a shared bit-serial multiplier,
//  restoring divider and square root
//  sample: scans the slews, picks the segment, on a ramp a multiply and divide
//  synchronous reset sets config, state, start time, rsp_valid and the plans
//  a result waits in the output register while the next item is taken
// ----------------------------------------------------------------------------
`default_nettype none

module three_slew_rate_profile_generator #(
   parameter int NUM_SLEWS = tsrp_pkg::NUM_SLEWS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_mode,
   input  wire logic [63:0]                     req_time_ns,
   input  wire logic signed [31:0]              req_body_rate_x,
   input  wire logic signed [31:0]              req_body_rate_y,
   input  wire logic signed [31:0]              req_body_rate_z,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [31:0]                   rsp_ref_rate_x,
   output logic signed [31:0]                   rsp_ref_rate_y,
   output logic signed [31:0]                   rsp_ref_rate_z,
   output logic signed [31:0]                   rsp_ref_accel_x,
   output logic signed [31:0]                   rsp_ref_accel_y,
   output logic signed [31:0]                   rsp_ref_accel_z,
   output logic signed [31:0]                   rsp_rate_error_x,
   output logic signed [31:0]                   rsp_rate_error_y,
   output logic signed [31:0]                   rsp_rate_error_z,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [tsrp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [tsrp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tsrp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   localparam int IW    = (NUM_SLEWS > 1) ? $clog2(NUM_SLEWS) : 1;
   localparam int NS_W  = tsrp_pkg::NS_W;
   localparam int Q_W   = tsrp_pkg::Q_W;
   localparam int FW    = tsrp_pkg::FLD_W;
   localparam int CW    = tsrp_pkg::CFG_W;
   localparam int AW    = tsrp_pkg::AXIS_W;
   localparam int LO_W  = NS_W + $clog2(NUM_SLEWS + 1);
   localparam int MA_W  = tsrp_pkg::MUL_A_W;
   localparam int MB_W  = tsrp_pkg::MUL_B_W;
   localparam int DN_W  = tsrp_pkg::DIV_N_W;
   localparam int DD_W  = tsrp_pkg::DIV_D_W;

   function automatic logic [FW-1:0] fld(logic [CW-1:0] r, int i);
      logic [FW-1:0] f;
      f = '0;
      if (i >= 0 && i < 3) f = r[FW*i +: FW];
      return f;
   endfunction

   function automatic logic [1:0] axis_of(logic [AW-1:0] r, int i);
      logic [1:0] c;
      c = 2'd0;
      if (i < 3) c = r[2*i +: 2];
      return c;
   endfunction

   // configuration registers
   logic [CW-1:0] angle_ff, slew_time_ff, rlim_ff, torque_ff, inertia_ff;
   logic [AW-1:0] axis_ff;
   logic          csr_wr;

   // control
   tsrp_pkg::state_type state_ff, state_in;
   logic                fresh_ff;
   logic [IW-1:0]       slew_ff, slew_in;
   logic                last_slew;
   logic                req_accept;

   // plan
   logic [Q_W-1:0]  plan_accel_ff [NUM_SLEWS];
   logic [Q_W-1:0]  plan_peak_ff  [NUM_SLEWS];
   logic [NS_W-1:0] plan_total_ff [NUM_SLEWS];
   logic [NS_W-1:0] plan_ramp_ff  [NUM_SLEWS];
   logic [63:0]     start_time_ff, start_time_in;

   // working registers
   logic [Q_W-1:0]  amax_ff, amax_in, alpha_ff, alpha_in, peak_ff, peak_in;
   logic            big_ff, big_in;
   logic [NS_W-1:0] total_ff, total_in, ramp_ff, ramp_in;
   logic [63:0]     elapsed_ff, elapsed_in;
   logic [LO_W-1:0] lo_ff, lo_in, hi;
   logic [NS_W-1:0] t_ff, t_in, mb_ff, mb_in;
   logic [Q_W-1:0]  rate_ff, rate_in;
   logic [31:0]     acc_ff, acc_in;
   logic            found_ff, found_in;
   logic            hit;
   logic [31:0]     body_ff [3];

   // current slew fields
   logic [FW-1:0]   th, tt, tq, inr;
   logic [29:0]     wl;
   logic [1:0]      code;
   logic [NS_W-1:0] cur_total, cur_ramp;
   logic [Q_W-1:0]  cur_peak, cur_accel;
   logic            up, coast;
   logic [NS_W-1:0] coast48;
   logic [NS_W:0]   coast_sum;

   // arithmetic units
   logic            mul_start, mul_done, div_start, div_done, sqrt_start, sqrt_done;
   logic [MA_W-1:0] mul_a;
   logic [MB_W-1:0] mul_b;
   logic [tsrp_pkg::MUL_P_W-1:0] mul_prod;
   logic [DN_W-1:0] div_num, div_quo;
   logic [DD_W-1:0] div_den;
   logic [tsrp_pkg::SQRT_V_W-1:0] sqrt_v;
   logic [tsrp_pkg::SQRT_R_W-1:0] sqrt_root;
   logic [NS_W-1:0] quo_sat48;
   logic [Q_W-1:0]  quo_satq;

   // output
   logic        rsp_valid_ff, rsp_valid_in, out_load;
   logic [31:0] out_rate_ff [3];
   logic [31:0] out_acc_ff  [3];
   logic [31:0] out_err_ff  [3];
   logic [31:0] ax_rate [3];
   logic [31:0] ax_acc  [3];
   logic [31:0] ax_err  [3];

   tsrp_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .a (mul_a), .b (mul_b), .done (mul_done), .prod (mul_prod)
   );

   tsrp_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .num (div_num), .den (div_den), .done (div_done), .quo (div_quo)
   );

   tsrp_sqrt u_sqrt (
      .clock (clock), .reset (reset), .start (sqrt_start),
      .v (sqrt_v), .done (sqrt_done), .root (sqrt_root)
   );

   // ------------------------------------------------------------------
   // configuration port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff     <= '0;
         slew_time_ff <= '0;
         rlim_ff      <= '0;
         axis_ff      <= tsrp_pkg::AXIS_RESET;
         torque_ff    <= '0;
         inertia_ff   <= '0;
      end else if (csr_wr) begin
         case (tsrp_pkg::csr_reg_type'(csr_paddr[5:3]))
            tsrp_pkg::REG_ANGLE:   angle_ff     <= csr_pwdata[CW-1:0];
            tsrp_pkg::REG_TIME:    slew_time_ff <= csr_pwdata[CW-1:0];
            tsrp_pkg::REG_RLIM:    rlim_ff      <= csr_pwdata[CW-1:0];
            tsrp_pkg::REG_AXIS:    axis_ff      <= csr_pwdata[AW-1:0];
            tsrp_pkg::REG_TORQUE:  torque_ff    <= csr_pwdata[CW-1:0];
            tsrp_pkg::REG_INERTIA: inertia_ff   <= csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (tsrp_pkg::csr_reg_type'(csr_paddr[5:3]))
         tsrp_pkg::REG_ANGLE:   csr_prdata = 64'(angle_ff);
         tsrp_pkg::REG_TIME:    csr_prdata = 64'(slew_time_ff);
         tsrp_pkg::REG_RLIM:    csr_prdata = 64'(rlim_ff);
         tsrp_pkg::REG_AXIS:    csr_prdata = 64'(axis_ff);
         tsrp_pkg::REG_TORQUE:  csr_prdata = 64'(torque_ff);
         tsrp_pkg::REG_INERTIA: csr_prdata = 64'(inertia_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // current slew
   // ------------------------------------------------------------------
   assign th        = fld(angle_ff, int'(slew_ff));
   assign tt        = fld(slew_time_ff, int'(slew_ff));
   assign wl        = {fld(rlim_ff, int'(slew_ff)), 10'd0};
   assign code      = axis_of(axis_ff, int'(slew_ff));
   assign tq        = fld(torque_ff, int'(code) - 1);
   assign inr       = fld(inertia_ff, int'(code) - 1);
   assign cur_total = plan_total_ff[slew_ff];
   assign cur_ramp  = plan_ramp_ff[slew_ff];
   assign cur_peak  = plan_peak_ff[slew_ff];
   assign cur_accel = plan_accel_ff[slew_ff];
   assign last_slew = (slew_ff == IW'(NUM_SLEWS - 1));

   assign hi    = lo_ff + LO_W'(cur_total);
   assign hit   = (elapsed_ff >= 64'(lo_ff)) && (elapsed_ff < 64'(hi));
   assign up    = (t_ff <= cur_ramp);
   assign coast = (t_ff < (cur_total - cur_ramp));

   assign quo_sat48 = (|div_quo[DN_W-1:NS_W]) ? tsrp_pkg::MAX48 : div_quo[NS_W-1:0];
   assign quo_satq  = (|div_quo[DN_W-1:Q_W]) ? tsrp_pkg::QMAX : div_quo[Q_W-1:0];
   assign coast48   = quo_sat48;
   assign coast_sum = {1'b0, coast48} + {1'b0, ramp_ff};

   assign req_stall  = (state_ff != tsrp_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_load   = (state_ff == tsrp_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsrp_pkg::ST_IDLE:
            if (req_accept) state_in = req_mode ? tsrp_pkg::ST_SCAN : tsrp_pkg::ST_PLAN_AMAX;
         tsrp_pkg::ST_PLAN_AMAX:  if (div_done) state_in = tsrp_pkg::ST_PLAN_TT;
         tsrp_pkg::ST_PLAN_TT:    if (mul_done) state_in = tsrp_pkg::ST_PLAN_ALPHA;
         tsrp_pkg::ST_PLAN_ALPHA: if (div_done) state_in = tsrp_pkg::ST_PLAN_PEAK;
         tsrp_pkg::ST_PLAN_PEAK:  if (div_done) state_in = tsrp_pkg::ST_PLAN_TOT;
         tsrp_pkg::ST_PLAN_TOT:
            if (mul_done) state_in = big_ff ? tsrp_pkg::ST_PLAN_Q : tsrp_pkg::ST_PLAN_LIMIT;
         tsrp_pkg::ST_PLAN_Q:     if (div_done) state_in = tsrp_pkg::ST_PLAN_SQRT;
         tsrp_pkg::ST_PLAN_SQRT:  if (sqrt_done) state_in = tsrp_pkg::ST_PLAN_RAMP2;
         tsrp_pkg::ST_PLAN_RAMP2: if (mul_done) state_in = tsrp_pkg::ST_PLAN_PEAK2;
         tsrp_pkg::ST_PLAN_PEAK2: if (mul_done) state_in = tsrp_pkg::ST_PLAN_LIMIT;
         tsrp_pkg::ST_PLAN_LIMIT:
            state_in = (peak_ff > Q_W'(wl)) ? tsrp_pkg::ST_PLAN_RAMP3_MUL
                                            : tsrp_pkg::ST_PLAN_STORE;
         tsrp_pkg::ST_PLAN_RAMP3_MUL: if (mul_done) state_in = tsrp_pkg::ST_PLAN_RAMP3_DIV;
         tsrp_pkg::ST_PLAN_RAMP3_DIV: if (div_done) state_in = tsrp_pkg::ST_PLAN_COAST_MUL;
         tsrp_pkg::ST_PLAN_COAST_MUL: if (mul_done) state_in = tsrp_pkg::ST_PLAN_COAST_DIV;
         tsrp_pkg::ST_PLAN_COAST_DIV: if (div_done) state_in = tsrp_pkg::ST_PLAN_STORE;
         tsrp_pkg::ST_PLAN_STORE:
            state_in = last_slew ? tsrp_pkg::ST_IDLE : tsrp_pkg::ST_PLAN_AMAX;
         tsrp_pkg::ST_SCAN:
            if (hit) state_in = tsrp_pkg::ST_SEL;
            else if (last_slew) state_in = tsrp_pkg::ST_OUT;
         tsrp_pkg::ST_SEL:
            if (up) state_in = (cur_ramp == '0) ? tsrp_pkg::ST_OUT : tsrp_pkg::ST_RATE_MUL;
            else if (coast) state_in = tsrp_pkg::ST_OUT;
            else state_in = tsrp_pkg::ST_RATE_MUL;
         tsrp_pkg::ST_RATE_MUL: if (mul_done) state_in = tsrp_pkg::ST_RATE_DIV;
         tsrp_pkg::ST_RATE_DIV: if (div_done) state_in = tsrp_pkg::ST_OUT;
         tsrp_pkg::ST_OUT:       if (out_load) state_in = tsrp_pkg::ST_IDLE;
         default:                state_in = tsrp_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // unit launches, one start in the first cycle of a state
   // ------------------------------------------------------------------
   always_comb begin
      mul_start  = 1'b0;
      div_start  = 1'b0;
      sqrt_start = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      div_num    = '0;
      div_den    = '0;
      sqrt_v     = div_quo[tsrp_pkg::SQRT_V_W-1:0];
      case (state_ff)
         tsrp_pkg::ST_PLAN_AMAX: begin
            div_start = fresh_ff;
            div_num   = DN_W'({tq, 20'd0});
            div_den   = DD_W'(inr);
         end
         tsrp_pkg::ST_PLAN_TT: begin
            mul_start = fresh_ff;
            mul_a     = MA_W'(tt);
            mul_b     = MB_W'(tt);
         end
         tsrp_pkg::ST_PLAN_ALPHA: begin
            div_start = fresh_ff;
            div_num   = DN_W'({th, 29'd0});
            div_den   = mul_prod[DD_W-1:0];
         end
         tsrp_pkg::ST_PLAN_PEAK: begin
            div_start = fresh_ff;
            div_num   = DN_W'({th, 20'd0});
            div_den   = DD_W'(tt);
         end
         tsrp_pkg::ST_PLAN_TOT: begin
            mul_start = fresh_ff;
            mul_a     = MA_W'(tt);
            mul_b     = MB_W'(tsrp_pkg::K_TOTAL);
         end
         tsrp_pkg::ST_PLAN_Q: begin
            div_start = fresh_ff;
            div_num   = DN_W'({th, 43'd0});
            div_den   = DD_W'(alpha_ff);
         end
         tsrp_pkg::ST_PLAN_SQRT: sqrt_start = fresh_ff;
         tsrp_pkg::ST_PLAN_RAMP2: begin
            mul_start = fresh_ff;
            mul_a     = MA_W'(sqrt_root);
            mul_b     = MB_W'(tsrp_pkg::K_RAMP);
         end
         tsrp_pkg::ST_PLAN_PEAK2: begin
            mul_start = fresh_ff;
            mul_a     = MA_W'(alpha_ff);
            mul_b     = MB_W'(sqrt_root);
         end
         tsrp_pkg::ST_PLAN_RAMP3_MUL: begin
            mul_start = fresh_ff;
            mul_a     = MA_W'(peak_ff);
            mul_b     = MB_W'(tsrp_pkg::K_NS);
         end
         tsrp_pkg::ST_PLAN_RAMP3_DIV: begin
            div_start = fresh_ff;
            div_num   = mul_prod;
            div_den   = DD_W'(alpha_ff);
         end
         tsrp_pkg::ST_PLAN_COAST_MUL: begin
            mul_start = fresh_ff;
            mul_a     = MA_W'({th, 11'd0});
            mul_b     = MB_W'(tsrp_pkg::K_NS);
         end
         tsrp_pkg::ST_PLAN_COAST_DIV: begin
            div_start = fresh_ff;
            div_num   = mul_prod;
            div_den   = DD_W'(peak_ff);
         end
         tsrp_pkg::ST_RATE_MUL: begin
            mul_start = fresh_ff;
            mul_a     = MA_W'(cur_peak);
            mul_b     = mb_ff;
         end
         tsrp_pkg::ST_RATE_DIV: begin
            div_start = fresh_ff;
            div_num   = mul_prod;
            div_den   = cur_ramp;
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // datapath registers
   // ------------------------------------------------------------------
   always_comb begin
      slew_in       = slew_ff;
      start_time_in = start_time_ff;
      amax_in       = amax_ff;
      alpha_in      = alpha_ff;
      big_in        = big_ff;
      peak_in       = peak_ff;
      total_in      = total_ff;
      ramp_in       = ramp_ff;
      elapsed_in    = elapsed_ff;
      lo_in         = lo_ff;
      t_in          = t_ff;
      mb_in         = mb_ff;
      rate_in       = rate_ff;
      acc_in        = acc_ff;
      found_in      = found_ff;
      case (state_ff)
         tsrp_pkg::ST_IDLE:
            if (req_accept) begin
               slew_in  = '0;
               lo_in    = '0;
               found_in = 1'b0;
               rate_in  = '0;
               acc_in   = '0;
               if (req_mode) elapsed_in = req_time_ns - start_time_ff;
               else start_time_in = req_time_ns;
            end
         tsrp_pkg::ST_PLAN_AMAX:
            if (div_done) amax_in = (code == 2'd0) ? tsrp_pkg::QMAX : quo_satq;
         tsrp_pkg::ST_PLAN_ALPHA:
            if (div_done) begin
               big_in   = (div_quo > DN_W'(amax_ff));
               alpha_in = big_in ? amax_ff : div_quo[Q_W-1:0];
            end
         tsrp_pkg::ST_PLAN_PEAK:
            if (div_done) peak_in = quo_satq;
         tsrp_pkg::ST_PLAN_TOT:
            if (mul_done) begin
               total_in = mul_prod[NS_W-1:0];
               ramp_in  = {1'b0, mul_prod[NS_W-1:1]};
            end
         tsrp_pkg::ST_PLAN_RAMP2:
            if (mul_done) begin
               ramp_in  = mul_prod[NS_W+6:7];
               total_in = {mul_prod[NS_W+5:7], 1'b0};
            end
         tsrp_pkg::ST_PLAN_PEAK2:
            if (mul_done) begin
               peak_in = (|mul_prod[tsrp_pkg::MUL_P_W-1:Q_W+16]) ? tsrp_pkg::QMAX
                                                                  : mul_prod[Q_W+15:16];
            end
         tsrp_pkg::ST_PLAN_LIMIT:
            if (peak_ff > Q_W'(wl)) peak_in = Q_W'(wl);
         tsrp_pkg::ST_PLAN_RAMP3_DIV:
            if (div_done) ramp_in = quo_sat48;
         tsrp_pkg::ST_PLAN_COAST_DIV:
            if (div_done) begin
               total_in = coast_sum[NS_W] ? tsrp_pkg::MAX48 : coast_sum[NS_W-1:0];
            end
         tsrp_pkg::ST_PLAN_STORE:
            if (!last_slew) slew_in = slew_ff + 1'b1;
         tsrp_pkg::ST_SCAN:
            if (hit) begin
               found_in = 1'b1;
               t_in     = NS_W'(elapsed_ff - 64'(lo_ff));
            end else begin
               lo_in = hi;
               if (!last_slew) slew_in = slew_ff + 1'b1;
            end
         tsrp_pkg::ST_SEL: begin
            mb_in   = up ? t_ff : (cur_total - t_ff);
            rate_in = cur_peak;
            if (up) acc_in = {1'b0, cur_accel};
            else if (coast) acc_in = '0;
            else acc_in = -{1'b0, cur_accel};
         end
         tsrp_pkg::ST_RATE_DIV:
            if (div_done) rate_in = div_quo[Q_W-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tsrp_pkg::ST_IDLE;
         fresh_ff      <= 1'b0;
         start_time_ff <= '0;
         for (int i = 0; i < NUM_SLEWS; i++) begin
            plan_accel_ff[i] <= '0;
            plan_peak_ff[i]  <= '0;
            plan_total_ff[i] <= '0;
            plan_ramp_ff[i]  <= '0;
         end
      end else begin
         state_ff      <= state_in;
         fresh_ff      <= (state_in != state_ff);
         start_time_ff <= start_time_in;
         if (state_ff == tsrp_pkg::ST_PLAN_STORE) begin
            plan_accel_ff[slew_ff] <= alpha_ff;
            plan_peak_ff[slew_ff]  <= peak_ff;
            plan_total_ff[slew_ff] <= total_ff;
            plan_ramp_ff[slew_ff]  <= ramp_ff;
         end
      end
      slew_ff    <= slew_in;
      amax_ff    <= amax_in;
      alpha_ff   <= alpha_in;
      big_ff     <= big_in;
      peak_ff    <= peak_in;
      total_ff   <= total_in;
      ramp_ff    <= ramp_in;
      elapsed_ff <= elapsed_in;
      lo_ff      <= lo_in;
      t_ff       <= t_in;
      mb_ff      <= mb_in;
      rate_ff    <= rate_in;
      acc_ff     <= acc_in;
      found_ff   <= found_in;
      if (req_accept) begin
         body_ff[0] <= req_body_rate_x;
         body_ff[1] <= req_body_rate_y;
         body_ff[2] <= req_body_rate_z;
      end
   end

   // ------------------------------------------------------------------
   // result: reference on the slew axis, saturated rate error
   // ------------------------------------------------------------------
   always_comb begin
      logic [32:0] diff;
      for (int a = 0; a < 3; a++) begin
         if (found_ff && (code == 2'(a + 1))) begin
            ax_rate[a] = {1'b0, rate_ff};
            ax_acc[a]  = acc_ff;
         end else begin
            ax_rate[a] = '0;
            ax_acc[a]  = '0;
         end
         diff = {body_ff[a][31], body_ff[a]} - {1'b0, ax_rate[a]};
         if (diff[32] != diff[31]) ax_err[a] = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         else ax_err[a] = diff[31:0];
      end
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
      if (out_load) begin
         for (int a = 0; a < 3; a++) begin
            out_rate_ff[a] <= ax_rate[a];
            out_acc_ff[a]  <= ax_acc[a];
            out_err_ff[a]  <= ax_err[a];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ref_rate_x   = out_rate_ff[0];
   assign rsp_ref_rate_y   = out_rate_ff[1];
   assign rsp_ref_rate_z   = out_rate_ff[2];
   assign rsp_ref_accel_x  = out_acc_ff[0];
   assign rsp_ref_accel_y  = out_acc_ff[1];
   assign rsp_ref_accel_z  = out_acc_ff[2];
   assign rsp_rate_error_x = out_err_ff[0];
   assign rsp_rate_error_y = out_err_ff[1];
   assign rsp_rate_error_z = out_err_ff[2];

endmodule

`default_nettype wire
